// ===== rtl/rsi_pkg.sv =====
// Shared constants for the ray/sphere intersection core.
package rsi_pkg;

  localparam int RES_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

endpackage

// ===== rtl/ray_sphere_intersect_core.sv =====
// Pipelined ray/sphere intersection: hit flag and near root in signed fixed point.
// The square root takes one stage per root bit, the divider one stage per quotient bit.
// Throughput: one item per cycle; busy stays low.
// Reset clears all valid bits and loads the sphere registers with their defaults.
module ray_sphere_intersect_core
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  output logic                         out_strobe,
  output logic                         out_hit_flag,
  output logic signed [RES_W-1:0]      out_ray_param,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [COORD_WIDTH-1:0]       cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = 2 * CW;
  localparam int DSW  = 2 * CW + 2;
  localparam int DW   = 4 * CW + 1;
  localparam int SQ_W = (DW + 2 * FRAC_BITS + 1) / 2;
  localparam int RW   = 2 * SQ_W;
  localparam int BW   = MW + FRAC_BITS;
  localparam int DV_W = ((BW > SQ_W) ? BW : SQ_W) + 1;
  localparam int EW   = (DV_W + 1 > RES_W + 2) ? DV_W + 1 : RES_W + 2;
  localparam int LAT  = SQ_W + DV_W + 8;

  // sphere registers
  logic signed [CW-1:0] center_x_r, center_y_r, center_z_r;
  logic [CW-2:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CW'(100);
      center_y_r <= CW'(42);
      center_z_r <= CW'(2000);
      radius_r   <= (CW-1)'(316);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_wdata;
        CFG_CENTER_Y: center_y_r <= cfg_wdata;
        CFG_CENTER_Z: center_z_r <= cfg_wdata;
        CFG_RADIUS:   radius_r   <= cfg_wdata[CW-2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: capture item
  logic                 s0_v_r;
  logic signed [CW-1:0] s0_ux_r, s0_uy_r, s0_uz_r;

  // stage 1: products
  logic                  s1_v_r;
  logic signed [MW-1:0]  s1_xx_r, s1_yy_r, s1_zz_r, s1_px_r, s1_py_r, s1_pz_r;
  logic signed [MW-1:0]  s1_cxx_r, s1_cyy_r, s1_czz_r;
  logic [MW-3:0]         s1_rr_r;

  // stage 2: sums
  logic                  s2_v_r, s2_dneg_r, s2_kpos_r, s2_hit_r;
  logic [MW-1:0]         s2_m_r, s2_ad_r, s2_kd_r;
  logic signed [DSW-1:0] d_sum;
  logic [MW-1:0]         c2_sum, m_sum;

  // stage 3: wide products
  logic                  s3_v_r, s3_dneg_r, s3_kpos_r, s3_hit_r;
  logic [MW-1:0]         s3_m_r, s3_ad_r;
  logic [2*MW-1:0]       s3_d2_r, s3_mk_r;

  // stage 4: discriminant
  logic                  s4_v_r, s4_dneg_r, s4_hit_r;
  logic [MW-1:0]         s4_m_r, s4_ad_r;
  logic [DW-1:0]         s4_disc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_comb begin
    m_sum  = s1_xx_r[MW-1:0] + s1_yy_r[MW-1:0] + s1_zz_r[MW-1:0];
    c2_sum = s1_cxx_r[MW-1:0] + s1_cyy_r[MW-1:0] + s1_czz_r[MW-1:0];
    d_sum  = DSW'(s1_px_r) + DSW'(s1_py_r) + DSW'(s1_pz_r);
  end

  always_ff @(posedge clk) begin
    s0_ux_r <= in_dir_x;
    s0_uy_r <= in_dir_y;
    s0_uz_r <= in_dir_z;

    s1_xx_r  <= s0_ux_r * s0_ux_r;
    s1_yy_r  <= s0_uy_r * s0_uy_r;
    s1_zz_r  <= s0_uz_r * s0_uz_r;
    s1_px_r  <= s0_ux_r * center_x_r;
    s1_py_r  <= s0_uy_r * center_y_r;
    s1_pz_r  <= s0_uz_r * center_z_r;
    s1_cxx_r <= center_x_r * center_x_r;
    s1_cyy_r <= center_y_r * center_y_r;
    s1_czz_r <= center_z_r * center_z_r;
    s1_rr_r  <= radius_r * radius_r;

    s2_m_r    <= m_sum;
    s2_hit_r  <= (m_sum != '0);
    s2_dneg_r <= d_sum[DSW-1];
    s2_ad_r   <= d_sum[DSW-1] ? MW'(-d_sum) : MW'(d_sum);
    s2_kpos_r <= (c2_sum >= MW'(s1_rr_r));
    s2_kd_r   <= (c2_sum >= MW'(s1_rr_r)) ? c2_sum - MW'(s1_rr_r) : MW'(s1_rr_r) - c2_sum;

    s3_m_r    <= s2_m_r;
    s3_ad_r   <= s2_ad_r;
    s3_dneg_r <= s2_dneg_r;
    s3_kpos_r <= s2_kpos_r;
    s3_hit_r  <= s2_hit_r;
    s3_d2_r   <= s2_ad_r * s2_ad_r;
    s3_mk_r   <= s2_m_r * s2_kd_r;

    s4_m_r    <= s3_m_r;
    s4_ad_r   <= s3_ad_r;
    s4_dneg_r <= s3_dneg_r;
    if (s3_kpos_r) begin
      s4_disc_r <= DW'(s3_d2_r) - DW'(s3_mk_r);
      s4_hit_r  <= s3_hit_r && (s3_d2_r >= s3_mk_r);
    end else begin
      s4_disc_r <= DW'(s3_d2_r) + DW'(s3_mk_r);
      s4_hit_r  <= s3_hit_r;
    end
  end

  // square root: one root bit per stage
  logic              sq_v_r    [0:SQ_W];
  logic              sq_hit_r  [0:SQ_W];
  logic              sq_dneg_r [0:SQ_W];
  logic [MW-1:0]     sq_m_r    [0:SQ_W];
  logic [MW-1:0]     sq_ad_r   [0:SQ_W];
  logic [SQ_W-1:0]   sq_root_r [0:SQ_W];
  logic [SQ_W+1:0]   sq_rem_r  [0:SQ_W];
  logic [RW-1:0]     sq_rad_r  [0:SQ_W];
  logic [SQ_W-1:0]   sq_root_nxt [0:SQ_W-1];
  logic [SQ_W+1:0]   sq_rem_nxt  [0:SQ_W-1];
  logic [SQ_W+1:0]   sq_sh  [0:SQ_W-1];
  logic [SQ_W+1:0]   sq_try [0:SQ_W-1];

  always_comb begin
    for (int k = 0; k < SQ_W; k++) begin
      sq_sh[k]  = {sq_rem_r[k][SQ_W-1:0], sq_rad_r[k][RW-1 -: 2]};
      sq_try[k] = {sq_root_r[k], 2'b01};
      if (sq_sh[k] >= sq_try[k]) begin
        sq_rem_nxt[k]  = sq_sh[k] - sq_try[k];
        sq_root_nxt[k] = {sq_root_r[k][SQ_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = sq_sh[k];
        sq_root_nxt[k] = {sq_root_r[k][SQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_W; k++) sq_v_r[k] <= 1'b0;
    end else begin
      sq_v_r[0] <= s4_v_r;
      for (int k = 0; k < SQ_W; k++) sq_v_r[k+1] <= sq_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    sq_hit_r[0]  <= s4_hit_r;
    sq_dneg_r[0] <= s4_dneg_r;
    sq_m_r[0]    <= s4_m_r;
    sq_ad_r[0]   <= s4_ad_r;
    sq_root_r[0] <= '0;
    sq_rem_r[0]  <= '0;
    sq_rad_r[0]  <= RW'(s4_disc_r) << (2 * FRAC_BITS);
    for (int k = 0; k < SQ_W; k++) begin
      sq_hit_r[k+1]  <= sq_hit_r[k];
      sq_dneg_r[k+1] <= sq_dneg_r[k];
      sq_m_r[k+1]    <= sq_m_r[k];
      sq_ad_r[k+1]   <= sq_ad_r[k];
      sq_root_r[k+1] <= sq_root_nxt[k];
      sq_rem_r[k+1]  <= sq_rem_nxt[k];
      sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
    end
  end

  // numerator
  logic [DV_W-1:0] big_d, root_ext;

  always_comb begin
    big_d    = DV_W'(sq_ad_r[SQ_W]) << FRAC_BITS;
    root_ext = DV_W'(sq_root_r[SQ_W]);
  end

  // divider: one quotient bit per stage, quotient shifts into the numerator word
  logic            dv_v_r   [0:DV_W];
  logic            dv_hit_r [0:DV_W];
  logic            dv_neg_r [0:DV_W];
  logic [MW-1:0]   dv_m_r   [0:DV_W];
  logic [DV_W-1:0] dv_num_r [0:DV_W];
  logic [MW-1:0]   dv_rem_r [0:DV_W];
  logic [MW:0]     dv_sh  [0:DV_W-1];
  logic [MW:0]     dv_dif [0:DV_W-1];

  always_comb begin
    for (int k = 0; k < DV_W; k++) begin
      dv_sh[k]  = {dv_rem_r[k], dv_num_r[k][DV_W-1]};
      dv_dif[k] = dv_sh[k] - {1'b0, dv_m_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DV_W; k++) dv_v_r[k] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[SQ_W];
      for (int k = 0; k < DV_W; k++) dv_v_r[k+1] <= dv_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    dv_hit_r[0] <= sq_hit_r[SQ_W];
    dv_m_r[0]   <= sq_m_r[SQ_W];
    dv_rem_r[0] <= '0;
    if (!sq_dneg_r[SQ_W] && big_d >= root_ext) begin
      dv_num_r[0] <= big_d - root_ext;
      dv_neg_r[0] <= 1'b0;
    end else if (!sq_dneg_r[SQ_W]) begin
      dv_num_r[0] <= root_ext - big_d;
      dv_neg_r[0] <= 1'b1;
    end else begin
      dv_num_r[0] <= big_d + root_ext;
      dv_neg_r[0] <= 1'b1;
    end
    for (int k = 0; k < DV_W; k++) begin
      dv_hit_r[k+1] <= dv_hit_r[k];
      dv_neg_r[k+1] <= dv_neg_r[k];
      dv_m_r[k+1]   <= dv_m_r[k];
      if (dv_sh[k] >= {1'b0, dv_m_r[k]}) begin
        dv_rem_r[k+1] <= dv_dif[k][MW-1:0];
        dv_num_r[k+1] <= {dv_num_r[k][DV_W-2:0], 1'b1};
      end else begin
        dv_rem_r[k+1] <= dv_sh[k][MW-1:0];
        dv_num_r[k+1] <= {dv_num_r[k][DV_W-2:0], 1'b0};
      end
    end
  end

  // round toward minus infinity and saturate
  logic [EW-1:0]    q_ext;
  logic [RES_W-1:0] res_val;

  always_comb begin
    q_ext = EW'(dv_num_r[DV_W])
          + EW'(dv_neg_r[DV_W] && (dv_rem_r[DV_W] != '0));
    if (dv_neg_r[DV_W]) begin
      res_val = (q_ext <= EW'(RES_MIN)) ? RES_W'(0) - q_ext[RES_W-1:0] : RES_MIN;
    end else begin
      res_val = (q_ext <= EW'(RES_MAX)) ? q_ext[RES_W-1:0] : RES_MAX;
    end
  end

  logic             out_strobe_r, out_hit_flag_r;
  logic [RES_W-1:0] out_ray_param_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_v_r[DV_W];
    end
  end

  always_ff @(posedge clk) begin
    out_hit_flag_r  <= dv_hit_r[DV_W];
    out_ray_param_r <= dv_hit_r[DV_W] ? res_val : '0;
  end

  assign out_strobe    = out_strobe_r;
  assign out_hit_flag  = out_hit_flag_r;
  assign out_ray_param = out_ray_param_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_hit_flag |-> out_ray_param == '0)
    else $error("miss with nonzero distance");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(LAT) out_strobe)
    else $error("item result missing at pipeline exit");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> dv_v_r[DV_W] == $past(dv_v_r[DV_W]) || $past(dv_v_r[DV_W]))
    else $error("result strobe without a tracked item");

endmodule

// ===== tb/ray_sphere_intersect_checker.sv =====
// Checker for the ray/sphere core: predicts each hit flag and near root, compares strobed results.
`timescale 1ns / 100ps
module ray_sphere_intersect_checker
  import rsi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [15:0]   in_dir_x,
  input  logic signed [15:0]   in_dir_y,
  input  logic signed [15:0]   in_dir_z,
  input  logic                 out_strobe,
  input  logic                 out_hit_flag,
  input  logic signed [31:0]   out_ray_param,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  output int                   mismatches,
  output int                   pending,
  output int                   hits_seen,
  output int                   results_seen
);

  typedef struct packed {
    logic        hit;
    logic [31:0] t_q16;
  } ray_result_t;

  logic signed [15:0] sph_cx, sph_cy, sph_cz;
  logic [14:0]        sph_r;
  ray_result_t        expected_hits[$];

  function automatic logic [127:0] isqrt128(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] bitv;
    logic [127:0] t;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      t = res + bitv;
      if (x >= t) begin
        x   = x - t;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic ray_result_t near_root(logic signed [15:0] dx, logic signed [15:0] dy,
                                            logic signed [15:0] dz);
    ray_result_t  r;
    longint       ux, uy, uz, cx, cy, cz, d;
    logic [127:0] m, c2, r2, ad, d2, mk, disc, s, big_d, num, q, rem;
    logic         neg;
    ux = dx; uy = dy; uz = dz;
    cx = sph_cx; cy = sph_cy; cz = sph_cz;
    r = '0;
    m  = 128'(ux * ux + uy * uy + uz * uz);
    d  = ux * cx + uy * cy + uz * cz;
    c2 = 128'(cx * cx + cy * cy + cz * cz);
    r2 = 128'(longint'(sph_r) * longint'(sph_r));
    ad = 128'(d < 0 ? -d : d);
    if (m == 0) return r;
    d2 = ad * ad;
    if (c2 >= r2) begin
      mk = m * (c2 - r2);
      if (d2 < mk) return r;
      disc = d2 - mk;
    end else begin
      disc = d2 + m * (r2 - c2);
    end
    s     = isqrt128(disc << 32);
    big_d = ad << 16;
    if (d >= 0 && big_d >= s) begin
      num = big_d - s;
      neg = 1'b0;
    end else if (d >= 0) begin
      num = s - big_d;
      neg = 1'b1;
    end else begin
      num = big_d + s;
      neg = 1'b1;
    end
    q   = num / m;
    rem = num % m;
    r.hit = 1'b1;
    if (neg) begin
      if (rem != 0) q = q + 1;
      r.t_q16 = (q <= 128'h8000_0000) ? 32'(0 - q[31:0]) : RES_MIN;
    end else begin
      r.t_q16 = (q <= 128'h7FFF_FFFF) ? q[31:0] : RES_MAX;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  initial begin
    mismatches = 0; hits_seen = 0; results_seen = 0;
  end

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    ray_result_t want;
    if (!rst_n) begin
      sph_cx <= 16'sd100;
      sph_cy <= 16'sd42;
      sph_cz <= 16'sd2000;
      sph_r  <= 15'd316;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: sph_cx <= cfg_wdata;
          CFG_CENTER_Y: sph_cy <= cfg_wdata;
          CFG_CENTER_Z: sph_cz <= cfg_wdata;
          CFG_RADIUS:   sph_r  <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_hits.push_back(near_root(in_dir_x, in_dir_y, in_dir_z));
      if (out_strobe) begin
        results_seen++;
        if (out_hit_flag) hits_seen++;
        if (expected_hits.size() == 0) begin
          report("unexpected result", out_ray_param, 32'd0);
        end else begin
          want = expected_hits.pop_front();
          if (out_hit_flag !== want.hit) report("hit_flag", 32'(out_hit_flag), 32'(want.hit));
          if (out_ray_param !== want.t_q16) report("ray_param", out_ray_param, want.t_q16);
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the ray/sphere core: clock, reset, sphere settings and ray stimulus.
`timescale 1ns / 100ps
module tb_top;
  import rsi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 130;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [15:0]   in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic                 out_strobe, out_hit_flag;
  logic signed [31:0]   out_ray_param;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_X;
  logic [15:0]          cfg_wdata = '0;
  int                   mismatches, pending, hits_seen, results_seen;
  int                   cycles = 0;
  logic signed [15:0]   cur_c[3];

  always #4 clk = ~clk;

  ray_sphere_intersect_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_strobe(out_strobe), .out_hit_flag(out_hit_flag), .out_ray_param(out_ray_param),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ray_sphere_intersect_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_strobe(out_strobe), .out_hit_flag(out_hit_flag), .out_ray_param(out_ray_param),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .hits_seen(hits_seen),
    .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("[ray_sphere_intersect_core] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic send_ray(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z,
                          int gap);
    start    <= 1'b1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_sphere(logic signed [15:0] cx, logic signed [15:0] cy,
                             logic signed [15:0] cz, logic [15:0] rad);
    settle();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
    cur_c[0] = cx; cur_c[1] = cy; cur_c[2] = cz;
  endtask

  task automatic random_rays(int count);
    int   kind, num, den, burst;
    logic signed [15:0] x, y, z;
    burst = 0;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        num = $urandom_range(1, 8);
        den = $urandom_range(1, 8);
        x = clamp16(cur_c[0] * num / den + $signed($urandom_range(0, 64)) - 32);
        y = clamp16(cur_c[1] * num / den + $signed($urandom_range(0, 64)) - 32);
        z = clamp16(cur_c[2] * num / den + $signed($urandom_range(0, 64)) - 32);
      end else if (kind < 9) begin
        x = 16'($urandom()); y = 16'($urandom()); z = 16'($urandom());
      end else begin
        x = 16'($signed($urandom_range(0, 6)) - 3);
        y = 16'($signed($urandom_range(0, 6)) - 3);
        z = 16'($signed($urandom_range(0, 6)) - 3);
      end
      if (burst > 0) burst--;
      else if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 30);
      send_ray(x, y, z, burst > 0 ? 0 : pick_gap());
    end
  endtask

  initial begin
    cur_c[0] = 16'sd100; cur_c[1] = 16'sd42; cur_c[2] = 16'sd2000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_ray(16'sd0, 16'sd0, 16'sd0, 0);
    send_ray(16'sd100, 16'sd42, 16'sd2000, 0);
    send_ray(-16'sd100, -16'sd42, -16'sd2000, 1);
    send_ray(16'sd1, 16'sd0, 16'sd20, 0);
    send_ray(16'sd0, 16'sd0, 16'sd1, 2);
    send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_ray(16'sh7FFF, 16'sh8000, 16'sh0000, 3);
    send_ray(16'sd0, 16'sd0, 16'sh7FFF, 0);
    send_ray(16'sd0, 16'sd0, 16'sh8000, 0);
    send_ray(16'sd16, 16'sd0, 16'sd100, 0);
    send_ray(16'sd1000, 16'sd0, 16'sd0, 1);
    send_ray(16'sd0, 16'sd0, 16'sd0, 0);
    random_rays(220);

    load_sphere(16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_ray(16'sd1, 16'sd2, 16'sd3, 0);
    send_ray(16'sd0, 16'sd0, 16'sd0, 1);
    random_rays(60);

    load_sphere(16'sd0, 16'sd0, 16'sd0, 16'h7FFF);
    send_ray(16'sd1, 16'sd0, 16'sd0, 0);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 0);
    random_rays(100);

    load_sphere(16'sh8000, 16'sh8000, 16'sh8000, 16'h7FFF);
    send_ray(-16'sd1, -16'sd1, -16'sd1, 0);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 0);
    random_rays(130);

    load_sphere(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd1);
    send_ray(16'sd1, 16'sd1, 16'sd1, 0);
    random_rays(130);

    load_sphere(16'sd5, -16'sd3, 16'sd4, 16'd3);
    random_rays(120);

    repeat (2) begin
      load_sphere(16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom_range(0, 32767)));
      random_rays(60);
    end

    settle();
    $display("covered %0d rays (%0d hits) over eight sphere settings incl. extreme centers",
             results_seen, hits_seen);
    $display("and radii, zero and saturating directions, back-to-back and gapped starts");
    if (mismatches == 0 && pending == 0) begin
      $display("[ray_sphere_intersect_core] OK");
    end else begin
      $display("[ray_sphere_intersect_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== ray_sphere_intersect_core.f =====
rtl/rsi_pkg.sv
rtl/ray_sphere_intersect_core.sv
tb/ray_sphere_intersect_checker.sv
tb/tb_top.sv
